/* design/terrain_grid_bilinear_lookup_defines.svh */
// Assertion macros for the terrain grid bilinear lookup.
`ifndef TERRAIN_GRID_BILINEAR_LOOKUP_DEFINES_SVH
`define TERRAIN_GRID_BILINEAR_LOOKUP_DEFINES_SVH
`ifndef SYNTHESIS
`define TGBL_ASSERT_IMP(lbl, clk, rst, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("assertion failed");
`define TGBL_ASSERT_NXT(lbl, clk, rst, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("assertion failed");
`else
`define TGBL_ASSERT_IMP(lbl, clk, rst, a, c)
`define TGBL_ASSERT_NXT(lbl, clk, rst, a, c)
`endif
`endif

/* design/tgbl_pkg.sv */
// Shared types and constants of the terrain grid bilinear lookup.
package tgbl_pkg;
  localparam int DEF_MAX_ROWS = 128;
  localparam int DEF_MAX_COLS = 128;

  localparam int S_TDATA_W = 96;
  localparam int M_TDATA_W = 24;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam int DIVIDEND_W = 48;
  localparam int DIVISOR_W = 20;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic [CFG_INDEX_W-1:0] REG_SW_LAT = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SW_LON = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_SPACING = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_GRID_ROWS = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_GRID_COLS = 3'd4;

  localparam logic [19:0] SPACING_RESET = 20'd2778;
  localparam logic [7:0] GRID_SIZE_RESET = 8'd2;

  localparam logic [2:0] MS_NONE = 3'd0;
  localparam logic [2:0] MS_P1 = 3'd1;
  localparam logic [2:0] MS_V1P2 = 3'd2;
  localparam logic [2:0] MS_V2 = 3'd3;
  localparam logic [2:0] MS_P3 = 3'd4;
  localparam logic [2:0] MS_ACC = 3'd5;

  typedef struct packed {
    logic take;
    logic load;
    logic clamp;
    logic rd_en;
    logic [1:0] rd_sel;
    logic cap_en;
    logic [1:0] cap_sel;
    logic [2:0] mstep;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic loaded;
    logic div_busy;
  } status_t;
endpackage

/* design/tgbl_div.sv */
// Restoring divider, one quotient bit per cycle.
module tgbl_div (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic [tgbl_pkg::DIVIDEND_W-1:0] dividend,
  input  logic [tgbl_pkg::DIVISOR_W-1:0] divisor,
  output logic busy,
  output logic [tgbl_pkg::DIVIDEND_W-1:0] quotient
);
  import tgbl_pkg::*;

  localparam int CNT_W = $clog2(DIVIDEND_W);

  logic [CNT_W-1:0] count;
  logic [DIVIDEND_W-1:0] dd;
  logic [DIVISOR_W-1:0] rem;
  logic [DIVISOR_W:0] trial;
  logic [DIVISOR_W:0] diff;
  logic ge;

  assign trial = {rem, dd[DIVIDEND_W-1]};
  assign diff = trial - {1'b0, divisor};
  assign ge = trial >= {1'b0, divisor};
  assign quotient = dd;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      count <= '0;
    end else if (start) begin
      busy <= 1'b1;
      count <= '0;
    end else if (busy) begin
      if (count == CNT_W'(DIVIDEND_W - 1)) busy <= 1'b0;
      count <= count + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dd <= dividend;
      rem <= '0;
    end else if (busy) begin
      rem <= ge ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
      dd <= {dd[DIVIDEND_W-2:0], ge};
    end
  end
endmodule

/* design/tgbl_datapath.sv */
// Datapath: configuration, grid memory, coordinate split and blend arithmetic.
module tgbl_datapath #(
  parameter int MAX_ROWS = tgbl_pkg::DEF_MAX_ROWS,
  parameter int MAX_COLS = tgbl_pkg::DEF_MAX_COLS
) (
  input  logic clk,
  input  logic rst,
  input  tgbl_pkg::cmd_t cmd,
  output tgbl_pkg::status_t status,
  input  logic [tgbl_pkg::S_TDATA_W-1:0] s_tdata,
  input  logic s_tlast,
  input  logic cfg_we,
  input  logic [tgbl_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [tgbl_pkg::CFG_DATA_W-1:0] cfg_data,
  output logic [tgbl_pkg::M_TDATA_W-1:0] m_tdata,
  output logic m_tuser
);
  import tgbl_pkg::*;

  localparam int RW = $clog2(MAX_ROWS);
  localparam int CW = $clog2(MAX_COLS);
  localparam int RSW = $clog2(MAX_ROWS + 1);
  localparam int CSW = $clog2(MAX_COLS + 1);
  localparam int DEPTH = MAX_ROWS * MAX_COLS;
  localparam int AW = $clog2(DEPTH);

  logic [30:0] sw_lat;
  logic [31:0] sw_lon;
  logic [19:0] spacing;
  logic [7:0] grid_rows;
  logic [7:0] grid_cols;
  logic loaded;
  logic qvalid;

  logic [6:0] in_row;
  logic [6:0] in_col;
  logic signed [15:0] in_sample;
  logic [30:0] in_lat;
  logic [31:0] in_lon;

  assign in_row = s_tdata[6:0];
  assign in_col = s_tdata[13:7];
  assign in_sample = s_tdata[29:14];
  assign in_lat = s_tdata[60:30];
  assign in_lon = s_tdata[92:61];

  always_ff @(posedge clk) begin
    if (rst) begin
      sw_lat <= '0;
      sw_lon <= '0;
      spacing <= SPACING_RESET;
      grid_rows <= GRID_SIZE_RESET;
      grid_cols <= GRID_SIZE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SW_LAT: sw_lat <= cfg_data[30:0];
        REG_SW_LON: sw_lon <= cfg_data;
        REG_SPACING: spacing <= cfg_data[19:0];
        REG_GRID_ROWS: grid_rows <= cfg_data[7:0];
        REG_GRID_COLS: grid_cols <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) loaded <= 1'b0;
    else if (cmd.load && s_tlast) loaded <= 1'b1;
  end

  always_ff @(posedge clk) begin
    if (cmd.take) qvalid <= loaded;
  end

  assign status.loaded = loaded;

  // Effective grid size and spacing
  logic [19:0] sp_eff;
  logic [RSW-1:0] nrows;
  logic [CSW-1:0] ncols;

  assign sp_eff = (spacing == '0) ? 20'd1 : spacing;

  always_comb begin
    if (grid_rows < 8'd2) nrows = RSW'(2);
    else if (32'(grid_rows) > 32'(MAX_ROWS)) nrows = RSW'(MAX_ROWS);
    else nrows = RSW'(grid_rows);
    if (grid_cols < 8'd2) ncols = CSW'(2);
    else if (32'(grid_cols) > 32'(MAX_COLS)) ncols = CSW'(MAX_COLS);
    else ncols = CSW'(grid_cols);
  end

  // Offsets from the corner, clamped below at zero
  logic signed [32:0] dlat;
  logic signed [32:0] dlon;
  logic [DIVIDEND_W-1:0] lat_dividend;
  logic [DIVIDEND_W-1:0] lon_dividend;

  assign dlat = {{2{in_lat[30]}}, in_lat} - {{2{sw_lat[30]}}, sw_lat};
  assign dlon = {in_lon[31], in_lon} - {sw_lon[31], sw_lon};
  assign lat_dividend = dlat[32] ? '0 : {dlat[31:0], 16'd0};
  assign lon_dividend = dlon[32] ? '0 : {dlon[31:0], 16'd0};

  logic lat_busy;
  logic lon_busy;
  logic div_start;
  logic [DIVIDEND_W-1:0] lat_quot;
  logic [DIVIDEND_W-1:0] lon_quot;

  // Only a query on a loaded grid needs the split
  assign div_start = cmd.take && loaded;

  tgbl_div u_div_lat (
    .clk(clk), .rst(rst), .start(div_start), .dividend(lat_dividend),
    .divisor(sp_eff), .busy(lat_busy), .quotient(lat_quot)
  );

  tgbl_div u_div_lon (
    .clk(clk), .rst(rst), .start(div_start), .dividend(lon_dividend),
    .divisor(sp_eff), .busy(lon_busy), .quotient(lon_quot)
  );

  assign status.div_busy = lat_busy | lon_busy;

  // Cell index and Q16 fraction; at or past the far edge use the last cell, fraction one
  logic [RW-1:0] ri;
  logic [CW-1:0] ci;
  logic [16:0] fy;
  logic [16:0] fx;

  always_ff @(posedge clk) begin
    if (cmd.clamp) begin
      if (lat_quot[47:16] >= 32'(nrows) - 32'd1) begin
        ri <= RW'(nrows - RSW'(2));
        fy <= 17'h10000;
      end else begin
        ri <= lat_quot[RW+15:16];
        fy <= {1'b0, lat_quot[15:0]};
      end
      if (lon_quot[47:16] >= 32'(ncols) - 32'd1) begin
        ci <= CW'(ncols - CSW'(2));
        fx <= 17'h10000;
      end else begin
        ci <= lon_quot[CW+15:16];
        fx <= {1'b0, lon_quot[15:0]};
      end
    end
  end

  // Grid memory
  logic signed [15:0] mem [DEPTH];
  logic signed [15:0] rdata;
  logic [AW-1:0] waddr;
  logic [AW-1:0] raddr;
  logic in_range;
  logic [RW-1:0] rd_row;
  logic [CW-1:0] rd_col;

  assign in_range = (32'(in_row) < 32'(MAX_ROWS)) && (32'(in_col) < 32'(MAX_COLS));
  assign waddr = AW'(in_row) * AW'(MAX_COLS) + AW'(in_col);
  assign rd_row = ri + RW'(cmd.rd_sel[1]);
  assign rd_col = ci + CW'(cmd.rd_sel[0]);
  assign raddr = AW'(rd_row) * AW'(MAX_COLS) + AW'(rd_col);

  always_ff @(posedge clk) begin
    if (cmd.load && in_range) mem[waddr] <= in_sample;
    if (cmd.rd_en) rdata <= mem[raddr];
  end

  logic signed [15:0] kq [4];

  always_ff @(posedge clk) begin
    if (cmd.cap_en) kq[cmd.cap_sel] <= rdata;
  end

  // Blend: one shared multiplier, stepped by the controller
  logic signed [33:0] mul_a;
  logic signed [17:0] mul_b;
  logic signed [51:0] prod;
  logic signed [32:0] v1;
  logic signed [32:0] v2;
  logic signed [47:0] acc;
  logic signed [23:0] res_elev;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    acc = 48'(signed'({v1, 16'd0})) + 48'(prod);
    case (cmd.mstep)
      MS_P1: begin
        mul_a = 34'(kq[1]) - 34'(kq[0]);
        mul_b = signed'({1'b0, fx});
      end
      MS_V1P2: begin
        mul_a = 34'(kq[3]) - 34'(kq[2]);
        mul_b = signed'({1'b0, fx});
      end
      MS_P3: begin
        mul_a = 34'(v2) - 34'(v1);
        mul_b = signed'({1'b0, fy});
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.mstep != MS_NONE) prod <= mul_a * mul_b;
    case (cmd.mstep)
      MS_V1P2: v1 <= 33'(signed'({kq[0], 16'd0})) + 33'(prod);
      MS_V2: v2 <= 33'(signed'({kq[2], 16'd0})) + 33'(prod);
      MS_ACC: res_elev <= acc[47:24];
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      m_tdata <= qvalid ? res_elev : '0;
      m_tuser <= qvalid;
    end
  end
endmodule

/* design/tgbl_ctrl.sv */
// Controller state machine: input and output handshakes, query sequencing.
`include "terrain_grid_bilinear_lookup_defines.svh"
module tgbl_ctrl (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  input  logic s_tuser,
  output logic m_tvalid,
  input  logic m_tready,
  input  tgbl_pkg::status_t status,
  output tgbl_pkg::cmd_t cmd
);
  import tgbl_pkg::*;

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_DIV = 4'd1;
  localparam logic [3:0] ST_CLP = 4'd2;
  localparam logic [3:0] ST_RD0 = 4'd3;
  localparam logic [3:0] ST_RD1 = 4'd4;
  localparam logic [3:0] ST_RD2 = 4'd5;
  localparam logic [3:0] ST_RD3 = 4'd6;
  localparam logic [3:0] ST_RD4 = 4'd7;
  localparam logic [3:0] ST_M0 = 4'd8;
  localparam logic [3:0] ST_M1 = 4'd9;
  localparam logic [3:0] ST_M2 = 4'd10;
  localparam logic [3:0] ST_M3 = 4'd11;
  localparam logic [3:0] ST_M4 = 4'd12;
  localparam logic [3:0] ST_OUT = 4'd13;

  logic [3:0] state;
  logic [3:0] state_next;
  logic accept;

  assign s_tready = (state == ST_IDLE);
  assign accept = s_tvalid && s_tready;

  always_comb begin
    cmd = '0;
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          if (s_tuser == OP_LOAD) begin
            cmd.load = 1'b1;
          end else begin
            cmd.take = 1'b1;
            state_next = status.loaded ? ST_DIV : ST_OUT;
          end
        end
      end
      ST_DIV: if (!status.div_busy) state_next = ST_CLP;
      ST_CLP: begin
        cmd.clamp = 1'b1;
        state_next = ST_RD0;
      end
      ST_RD0: begin
        cmd.rd_en = 1'b1;
        cmd.rd_sel = 2'd0;
        state_next = ST_RD1;
      end
      ST_RD1: begin
        cmd.rd_en = 1'b1;
        cmd.rd_sel = 2'd1;
        cmd.cap_en = 1'b1;
        cmd.cap_sel = 2'd0;
        state_next = ST_RD2;
      end
      ST_RD2: begin
        cmd.rd_en = 1'b1;
        cmd.rd_sel = 2'd2;
        cmd.cap_en = 1'b1;
        cmd.cap_sel = 2'd1;
        state_next = ST_RD3;
      end
      ST_RD3: begin
        cmd.rd_en = 1'b1;
        cmd.rd_sel = 2'd3;
        cmd.cap_en = 1'b1;
        cmd.cap_sel = 2'd2;
        state_next = ST_RD4;
      end
      ST_RD4: begin
        cmd.cap_en = 1'b1;
        cmd.cap_sel = 2'd3;
        state_next = ST_M0;
      end
      ST_M0: begin
        cmd.mstep = MS_P1;
        state_next = ST_M1;
      end
      ST_M1: begin
        cmd.mstep = MS_V1P2;
        state_next = ST_M2;
      end
      ST_M2: begin
        cmd.mstep = MS_V2;
        state_next = ST_M3;
      end
      ST_M3: begin
        cmd.mstep = MS_P3;
        state_next = ST_M4;
      end
      ST_M4: begin
        cmd.mstep = MS_ACC;
        state_next = ST_OUT;
      end
      ST_OUT: begin
        // hold until the output register is free
        if (!m_tvalid || m_tready) begin
          cmd.out_load = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
    end
  end

  `TGBL_ASSERT_IMP(a_idle_div_quiet, clk, rst, state == ST_IDLE, !status.div_busy)
  `TGBL_ASSERT_NXT(a_unloaded_to_out, clk, rst, cmd.take && !status.loaded, state == ST_OUT)
  `TGBL_ASSERT_NXT(a_result_held, clk, rst, m_tvalid && !m_tready, m_tvalid)
endmodule

/* design/terrain_grid_bilinear_lookup.sv */
// Top level of the terrain grid bilinear lookup.
// Usage:
//   Slave stream: s_tuser selects load (0) or query (1). A load item writes
//   one grid sample; s_tlast on a load marks the grid valid.
//   A query item gives lat/lon; one result item follows on the master stream
//   with the Q8 elevation in m_tdata and the valid flag in m_tuser.
//   Configuration writes go through cfg_valid/cfg_index/cfg_data, always ready.
// Query sequence:
//   A load is taken without leaving the idle state. A query waits on the
//   bit-serial dividers that split lat and lon by the spacing, then runs a
//   clamp step, grid reads one at a time, blend steps on the shared
//   multiplier and an output step. A new item is taken only when the
//   controller is back in idle, so queries do not overlap. A query before
//   the grid is loaded goes straight to the output step and gives
//   elevation 0 and flag 0.
// Reset:
//   Synchronous; clears the loaded flag and sets config registers to their defaults.
//   Grid memory is not cleared.
// Stalls:
//   A finished result holds in the output register while m_tready is low;
//   loads are still taken meanwhile, a next query waits at its last step.
module terrain_grid_bilinear_lookup #(
  parameter int MAX_ROWS = tgbl_pkg::DEF_MAX_ROWS,
  parameter int MAX_COLS = tgbl_pkg::DEF_MAX_COLS
) (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  // row[6:0], col[13:7], sample[29:14], query_lat[60:30], query_lon[92:61]
  input  logic [tgbl_pkg::S_TDATA_W-1:0] s_tdata,
  // opcode[0]
  input  logic s_tuser,
  input  logic s_tlast,
  output logic m_tvalid,
  input  logic m_tready,
  // elevation_q8[23:0]
  output logic [tgbl_pkg::M_TDATA_W-1:0] m_tdata,
  // valid_res[0]
  output logic m_tuser,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [tgbl_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [tgbl_pkg::CFG_DATA_W-1:0] cfg_data
);
  import tgbl_pkg::*;

  cmd_t cmd;
  status_t status;

  assign cfg_ready = 1'b1;

  tgbl_ctrl u_ctrl (
    .clk(clk), .rst(rst), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .s_tuser(s_tuser), .m_tvalid(m_tvalid), .m_tready(m_tready),
    .status(status), .cmd(cmd)
  );

  tgbl_datapath #(.MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .status(status), .s_tdata(s_tdata),
    .s_tlast(s_tlast), .cfg_we(cfg_valid && cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );
endmodule
